// ===== sv/slot_allocator_free_stack_macros.svh =====
// ----------------------------------------------------------------------------
// slot allocator assertion macros
// shared property shorthands for the checker, clocked on clock, reset high
// ----------------------------------------------------------------------------
`ifndef SLOT_ALLOCATOR_FREE_STACK_MACROS_SVH
`define SLOT_ALLOCATOR_FREE_STACK_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLAFS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SLAFS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/slafs_pkg.sv =====
// ----------------------------------------------------------------------------
// slafs_pkg
// shared widths, codes and types of the slot allocator
// ----------------------------------------------------------------------------
package slafs_pkg;

   // number of slots the allocator manages
   localparam int SLOT_COUNT = 256;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int CNT_W      = SLOT_W + 1;

   localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_COUNT);

   // request kind
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // response status
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // free stack memory access from the controller
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [SLOT_W-1:0] wr_data;
   } mem_req_type;

endpackage

// ===== sv/slafs_ram.sv =====
// ----------------------------------------------------------------------------
// slafs_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module slafs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/slafs_ctrl.sv =====
// ----------------------------------------------------------------------------
// slafs_ctrl
// request sequencer: pops or pushes the free stack, keeps the high-water
// mark and the used count, and holds the response register
// ----------------------------------------------------------------------------
module slafs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [slafs_pkg::SLOT_W-1:0]  req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [slafs_pkg::SLOT_W-1:0]  rsp_granted_slot,
   output logic [slafs_pkg::CNT_W-1:0]   rsp_used_slots,
   output slafs_pkg::mem_req_type        mem_req,
   input  logic [slafs_pkg::SLOT_W-1:0]  mem_rd_data
);
   import slafs_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type          state_ff, state_in;
   req_kind_type       kind_ff, kind_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   free_depth_ff, free_depth_in;
   logic [CNT_W-1:0]   high_mark_ff, high_mark_in;
   logic [CNT_W-1:0]   used_total_ff, used_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_grant_ff, rsp_grant_in;
   logic [CNT_W-1:0]   rsp_used_ff, rsp_used_in;

   logic               accept;
   logic               out_free;
   logic               commit;
   logic [CNT_W-1:0]   used_up;
   logic [CNT_W-1:0]   used_down;
   logic [CNT_W-1:0]   depth_dec;
   logic [CNT_W-1:0]   mark_dec;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == S_EXEC) && out_free;

   // saturating used count steps
   assign used_up   = (used_total_ff < SLOT_LIMIT) ? used_total_ff + 1'b1 : used_total_ff;
   assign used_down = (used_total_ff != '0) ? used_total_ff - 1'b1 : used_total_ff;
   assign depth_dec = free_depth_ff - 1'b1;
   assign mark_dec  = high_mark_ff - 1'b1;

   // next state, stack bookkeeping and response
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      free_depth_in = free_depth_ff;
      high_mark_in  = high_mark_ff;
      used_total_in = used_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_used_in   = rsp_used_ff;

      mem_req.rd_en   = accept;
      mem_req.rd_addr = depth_dec[SLOT_W-1:0];
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = free_depth_ff[SLOT_W-1:0];
      mem_req.wr_data = idx_ff;

      // response taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // latch request, top of stack read is in flight
      if (accept) begin
         state_in = S_EXEC;
         kind_in  = req_kind_type'(req_type);
         idx_in   = req_slot_index;
      end

      if (commit) begin
         state_in      = S_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_grant_in  = '0;
         unique case (kind_ff)
            REQ_ALLOC: begin
               // pop first; a stale entry falls through to the mark
               if (free_depth_ff != '0) begin
                  free_depth_in = depth_dec;
               end
               if ((free_depth_ff != '0) && ({1'b0, mem_rd_data} < high_mark_ff)) begin
                  rsp_grant_in  = mem_rd_data;
                  used_total_in = used_up;
               end else if (high_mark_ff < SLOT_LIMIT) begin
                  rsp_grant_in  = high_mark_ff[SLOT_W-1:0];
                  high_mark_in  = high_mark_ff + 1'b1;
                  used_total_in = used_up;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end
            REQ_FREE: begin
               priority if ({1'b0, idx_ff} >= high_mark_ff) begin
                  rsp_status_in = ST_BAD;
               end else if ({1'b0, idx_ff} == mark_dec) begin
                  // last slot handed out: lower the mark
                  high_mark_in  = mark_dec;
                  used_total_in = used_down;
               end else if (free_depth_ff < SLOT_LIMIT) begin
                  mem_req.wr_en = 1'b1;
                  free_depth_in = free_depth_ff + 1'b1;
                  used_total_in = used_down;
               end else begin
                  // stack full, likely a double free
                  rsp_status_in = ST_BAD;
               end
            end
            default: begin
               rsp_status_in = ST_BAD;
            end
         endcase
         rsp_used_in = used_total_in;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_depth_ff <= '0;
         high_mark_ff  <= '0;
         used_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_depth_ff <= free_depth_in;
         high_mark_ff  <= high_mark_in;
         used_total_ff <= used_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_grant_ff;
   assign rsp_used_slots   = rsp_used_ff;

endmodule

// ===== sv/slot_allocator_free_stack.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_free_stack
// slot allocator with a lifo free stack in ram and a high-water mark
// ----------------------------------------------------------------------------
// A request is accepted in the idle state, where the top of the free stack
// is read from the stack ram; in the exec state the registered ram read has
// returned, and the request commits into the response register. A new
// request is accepted while a response still waits; the commit stalls
// only while the response register is still full. There is no clearing
// pass: the ram read data is used only while the stack is not empty.
module slot_allocator_free_stack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic [slafs_pkg::SLOT_W-1:0]  req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [slafs_pkg::SLOT_W-1:0]  rsp_granted_slot,
   output logic [slafs_pkg::CNT_W-1:0]   rsp_used_slots
);
   import slafs_pkg::*;

   mem_req_type       mem_req;
   logic [SLOT_W-1:0] mem_rd_data;

   // request sequencer
   slafs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_used_slots   (rsp_used_slots),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data)
   );

   // free stack storage
   slafs_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOT_COUNT)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== sv/slafs_checker.sv =====
// ----------------------------------------------------------------------------
// slafs_checker
// port-level checks of the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "slot_allocator_free_stack_macros.svh"

module slafs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic [slafs_pkg::SLOT_W-1:0]  rsp_granted_slot,
   input logic [slafs_pkg::CNT_W-1:0]   rsp_used_slots
);
   import slafs_pkg::*;

   // a stalled response holds
   `SLAFS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_slot) && $stable(rsp_used_slots), "response changed while stalled")

   // one request at a time: not ready the cycle after an accept
   `SLAFS_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request accepted while one is in flight")

   // failed responses carry no grant
   `SLAFS_ASSERT_NOW(a_no_grant_on_fail, rsp_valid && (rsp_status != ST_OK), rsp_granted_slot == '0, "grant on failed request")

   // used count bounded by capacity
   `SLAFS_ASSERT_NOW(a_used_bound, rsp_valid, rsp_used_slots <= SLOT_LIMIT, "used count over capacity")

endmodule

bind slot_allocator_free_stack slafs_checker u_slafs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_used_slots   (rsp_used_slots)
);

// ===== tb/sv/slot_allocator_free_stack_tb.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_tb
// Drives allocate and free requests into the slot allocator and checks every
// response against a behavioral copy of the allocator: free stack, high-water
// mark and used count. A short directed sequence comes first. Random phases
// follow: mixed traffic, a fill to the full condition, a drain, and a
// double-free storm that overflows the free stack and saturates the used
// count. The sender idles in bursts and the receiver stalls on its own
// pattern.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slafs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  used;
   } slot_result_type;

   // behavioral copy of the allocator and its outstanding responses
   class slot_alloc_tracker;
      logic [SLOT_W-1:0] free_slots [SLOT_COUNT];
      int                depth;
      int                mark;
      int                used;
      int                errors;
      int                full_hits;
      int                overflow_hits;
      slot_result_type   pending_results [$];

      task report(string msg);
         errors++;
         $display("%0t ns  mismatch: %s", $time, msg);
      endtask

      // update the allocator copy for one accepted request
      function void predict_request(req_kind_type kind, logic [SLOT_W-1:0] idx);
         slot_result_type res;
         logic [SLOT_W-1:0] cand;
         bit granted;
         res.status = ST_OK;
         res.slot   = '0;
         granted    = 1'b0;
         if (kind == REQ_ALLOC) begin
            // pop first; a popped slot at or above the mark is stale
            if (depth > 0) begin
               depth--;
               cand = free_slots[depth];
               if (int'(cand) < mark) begin
                  res.slot = cand;
                  if (used < SLOT_COUNT) used++;
                  granted = 1'b1;
               end
            end
            if (!granted) begin
               if (mark < SLOT_COUNT) begin
                  res.slot = SLOT_W'(mark);
                  mark++;
                  if (used < SLOT_COUNT) used++;
               end else begin
                  res.status = ST_FULL;
                  full_hits++;
               end
            end
         end else begin
            // free: last slot lowers the mark, others go on the stack
            if (int'(idx) < mark) begin
               if (int'(idx) == mark - 1) begin
                  mark--;
                  if (used > 0) used--;
               end else if (depth < SLOT_COUNT) begin
                  free_slots[depth] = idx;
                  depth++;
                  if (used > 0) used--;
               end else begin
                  res.status = ST_BAD;
                  overflow_hits++;
               end
            end else begin
               res.status = ST_BAD;
            end
         end
         res.used = CNT_W'(used);
         pending_results.push_back(res);
      endfunction

      // compare one accepted response with the oldest outstanding one
      task compare_result(logic [1:0] st, logic [SLOT_W-1:0] slot, logic [CNT_W-1:0] cnt);
         slot_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("response with none outstanding: status %0d slot %0d used %0d",
                             st, slot, cnt));
            return;
         end
         want = pending_results.pop_front();
         if (st !== want.status)
            report($sformatf("status %0d, wanted %0d", st, want.status));
         if (slot !== want.slot)
            report($sformatf("granted_slot %0d, wanted %0d", slot, want.slot));
         if (cnt !== want.used)
            report($sformatf("used_slots %0d, wanted %0d", cnt, want.used));
      endtask
   endclass

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic              req_type       = 1'b0;
   logic [SLOT_W-1:0] req_slot_index = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [1:0]        rsp_status;
   logic [SLOT_W-1:0] rsp_granted_slot;
   logic [CNT_W-1:0]  rsp_used_slots;

   slot_alloc_tracker ledger = new;
   int                burst_left = 0;
   int                quiet_cycles = 0;
   int                stall_mode = 0;
   int                stall_left = 0;
   int                stall_phase = 0;

   slot_allocator_free_stack u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_used_slots   (rsp_used_slots)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stall pattern: open, random, periodic and sparse stretches
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 150);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2: rsp_ready <= (stall_phase % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.compare_result(rsp_status, rsp_granted_slot, rsp_used_slots);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("slot_allocator_free_stack_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // send one request, with a random gap at the start of each burst
   task automatic issue(req_kind_type kind, logic [SLOT_W-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_slot_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.predict_request(kind, idx);
   endtask

   // hold the sender until every outstanding response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.pending_results.size() != 0);
      burst_left = 0;
   endtask

   // free index: mostly live slots, some last slot, some out of range
   function automatic logic [SLOT_W-1:0] pick_free_index();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6 && ledger.mark > 0)
         return SLOT_W'($urandom_range(0, ledger.mark - 1));
      if (r == 6 && ledger.mark > 0)
         return SLOT_W'(ledger.mark - 1);
      if (r == 7 && ledger.mark < SLOT_COUNT)
         return SLOT_W'(ledger.mark);
      if (r == 8)
         return '1;
      return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
   endfunction

   task automatic random_mix(int count, int alloc_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < alloc_pct)
            issue(REQ_ALLOC, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
         else
            issue(REQ_FREE, pick_free_index());
      end
   endtask

   initial begin
      int budget;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: bad frees on an empty allocator, mark lowering,
      // pushes, zero saturation, stale pop, pops below the mark
      issue(REQ_FREE, 8'd0);
      issue(REQ_FREE, 8'd255);
      issue(REQ_ALLOC, 8'd0);
      issue(REQ_FREE, 8'd0);
      repeat (4) issue(REQ_ALLOC, 8'd0);
      issue(REQ_FREE, 8'd1);
      issue(REQ_FREE, 8'd2);
      issue(REQ_FREE, 8'd3);
      issue(REQ_FREE, 8'd2);
      issue(REQ_FREE, 8'd0);
      issue(REQ_ALLOC, 8'd0);
      issue(REQ_ALLOC, 8'd0);
      issue(REQ_ALLOC, 8'd0);
      issue(REQ_FREE, 8'd3);
      issue(REQ_FREE, 8'd4);
      issue(REQ_FREE, 8'haa);
      issue(REQ_FREE, 8'h55);
      issue(REQ_ALLOC, 8'hff);
      wait_drained();

      // mixed random traffic
      random_mix(100, 55);
      wait_drained();

      // fill up to the full condition, with some frees in between
      budget = 600;
      while (ledger.full_hits < 6 && budget > 0) begin
         random_mix(1, 85);
         budget--;
      end
      wait_drained();

      // drain mostly with frees
      random_mix(60, 25);

      // double frees of slot 0 until the free stack overflows
      while (ledger.mark < 2) issue(REQ_ALLOC, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
      while (ledger.overflow_hits < 3) issue(REQ_FREE, 8'd0);
      wait_drained();

      // pop the stack empty, then a few more to saturate the used count
      while (ledger.depth > 0) issue(REQ_ALLOC, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
      random_mix(30, 60);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0)
         $display("slot_allocator_free_stack_tb: clean");
      else
         $display("slot_allocator_free_stack_tb: errors");
      $finish;
   end

endmodule
